// ----- rtl/lfc_pkg.sv -----
package lfc_pkg;

    // field widths
    localparam int DUTY_BITS   = 8;
    localparam int OP_W        = 4;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 8;
    localparam int DIR_W       = 2;
    localparam int REPEATS_W   = 14;
    localparam int DURATION_W  = 23;
    localparam int AMOUNT_W    = 16;
    localparam int MODE_W      = 2;
    localparam int PULSES_W    = 15;
    localparam int BRIGHT_W    = 16;

    // serial units walk one bit of a time word per cycle
    localparam int SER_CNT_W   = $clog2(TIME_W);

    // milliseconds to microseconds
    localparam logic [9:0] MS_SCALE = 10'd1000;
    localparam int MUL_TAPS    = 10;
    localparam int MUL_CARRY_W = 4;
    localparam int MUL_SUM_W   = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // op codes
    localparam logic [OP_W-1:0] OP_TICK      = 4'd0;
    localparam logic [OP_W-1:0] OP_HARD_ON   = 4'd1;
    localparam logic [OP_W-1:0] OP_HARD_OFF  = 4'd2;
    localparam logic [OP_W-1:0] OP_TOGGLE    = 4'd3;
    localparam logic [OP_W-1:0] OP_ADJUST    = 4'd4;
    localparam logic [OP_W-1:0] OP_FADE_ONCE = 4'd5;
    localparam logic [OP_W-1:0] OP_FADE_REP  = 4'd6;
    localparam logic [OP_W-1:0] OP_FADE_EVER = 4'd7;
    localparam logic [OP_W-1:0] OP_STOP      = 4'd8;
    localparam logic [OP_W-1:0] OP_FADE_TO   = 4'd9;

    // fade modes, also used as fade-once directions
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd2;

    // status of a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } ser_status_t;

endpackage

// ----- rtl/lfc_in_if.sv -----
interface lfc_in_if;
    import lfc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic [TIME_W-1:0]            now_us;
    logic [LEVEL_W-1:0]           low_level;
    logic [LEVEL_W-1:0]           high_level;
    logic [DIR_W-1:0]             direction;
    logic [REPEATS_W-1:0]         repeats;
    logic [DURATION_W-1:0]        duration_ms;
    logic signed [AMOUNT_W-1:0]   amount;
    logic [LEVEL_W-1:0]           end_level;

    modport source (
        output valid, op, now_us, low_level, high_level, direction, repeats,
               duration_ms, amount, end_level,
        input  ready
    );

    modport sink (
        input  valid, op, now_us, low_level, high_level, direction, repeats,
               duration_ms, amount, end_level,
        output ready
    );

endinterface

// ----- rtl/lfc_out_if.sv -----
interface lfc_out_if;
    import lfc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DUTY_BITS-1:0]   pwm_duty;
    logic                   pwm_written;
    logic [MODE_W-1:0]      fade_mode;
    logic                   lamp_on;
    logic [PULSES_W-1:0]    pulses_left;

    modport source (
        output valid, pwm_duty, pwm_written, fade_mode, lamp_on, pulses_left,
        input  ready
    );

    modport sink (
        input  valid, pwm_duty, pwm_written, fade_mode, lamp_on, pulses_left,
        output ready
    );

endinterface

// ----- rtl/led_fade_controller.sv -----
// result path: direct commands and idle ticks go through the apply and output states;
// an active tick first runs a bit-serial 32-bit elapsed-time compare,
// fade commands first a bit-serial x1000 multiply, then a 32-step divide
// one word is in flight at a time; the next word can be accepted in the cycle the result
// turns valid; a stalled result holds the sequencer in its output state
// rst_n is asynchronous, active low; all fade state and the result valid clear to zero
module led_fade_controller (
    input  logic        clk,
    input  logic        rst_n,
    lfc_in_if.sink      item,
    lfc_out_if.source   result
);
    import lfc_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TCMP  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_APPLY = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // fade engine state
    logic [BRIGHT_W-1:0]    brightness_reg;
    logic [BRIGHT_W-1:0]    brightness_next;
    logic [MODE_W-1:0]      fade_mode_reg;
    logic [MODE_W-1:0]      fade_mode_next;
    logic                   lamp_on_reg;
    logic                   lamp_on_next;
    logic [PULSES_W-1:0]    half_pulses_reg;
    logic [PULSES_W-1:0]    half_pulses_next;
    logic [TIME_W-1:0]      step_interval_reg;
    logic [TIME_W-1:0]      step_interval_next;
    logic [LEVEL_W-1:0]     low_bound_reg;
    logic [LEVEL_W-1:0]     low_bound_next;
    logic [LEVEL_W-1:0]     high_bound_reg;
    logic [LEVEL_W-1:0]     high_bound_next;
    logic [TIME_W-1:0]      last_step_time_reg;
    logic [TIME_W-1:0]      last_step_time_next;

    // latched command word
    logic [OP_W-1:0]            op_reg;
    logic [TIME_W-1:0]          now_reg;
    logic [LEVEL_W-1:0]         lo_reg;
    logic [LEVEL_W-1:0]         hi_reg;
    logic [DIR_W-1:0]           dir_reg;
    logic [REPEATS_W-1:0]       reps_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;
    logic [LEVEL_W-1:0]         endl_reg;
    logic                       tick_active_reg;

    logic wrote_reg;
    logic wrote_next;

    // output register
    logic                   out_valid_reg;
    logic [DUTY_BITS-1:0]   out_duty_reg;
    logic                   out_written_reg;
    logic [MODE_W-1:0]      out_mode_reg;
    logic                   out_lamp_reg;
    logic [PULSES_W-1:0]    out_pulses_reg;

    // serial units
    ser_status_t            tcmp_st;
    ser_status_t            mul_st;
    ser_status_t            div_st;
    logic                   tcmp_elapsed;
    logic [TIME_W-1:0]      us_product;
    logic [TIME_W-1:0]      quotient;

    logic                   accept;
    logic                   fade_cmd_in;
    logic                   tick_active_in;
    logic                   tcmp_start;
    logic                   mul_start;
    logic                   div_start;
    logic                   out_free;

    logic [LEVEL_W-1:0]     span_a;
    logic [LEVEL_W-1:0]     span_b;
    logic [LEVEL_W-1:0]     span;
    logic [TIME_W-1:0]      new_interval;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    assign fade_cmd_in = (item.op == OP_FADE_ONCE) || (item.op == OP_FADE_REP)
                      || (item.op == OP_FADE_EVER) || (item.op == OP_FADE_TO);
    // a tick only moves anything while a fade runs or half-pulses remain
    assign tick_active_in = (half_pulses_reg != '0) || (fade_mode_reg != MODE_OFF);

    assign tcmp_start = accept && (item.op == OP_TICK) && tick_active_in;
    assign mul_start  = accept && fade_cmd_in;
    assign div_start  = (state_reg == S_MUL) && mul_st.done;

    // fade span: bounds for fade commands, current level to target for fade to
    assign span_a = (op_reg == OP_FADE_TO) ? brightness_reg[LEVEL_W-1:0] : lo_reg;
    assign span_b = (op_reg == OP_FADE_TO) ? endl_reg : hi_reg;
    assign span   = (span_a > span_b) ? (span_a - span_b) : (span_b - span_a);
    assign new_interval = (span == '0) ? '1 : quotient;

    assign out_free = !out_valid_reg || result.ready;

    lfc_tcmp u_tcmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (tcmp_start),
        .now_us    (item.now_us),
        .last_time (last_step_time_reg),
        .interval  (step_interval_reg),
        .status    (tcmp_st),
        .elapsed   (tcmp_elapsed)
    );

    lfc_mul1000 u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mul_start),
        .duration_ms (item.duration_ms),
        .status      (mul_st),
        .product     (us_product)
    );

    lfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (us_product),
        .divisor  (span),
        .status   (div_st),
        .quotient (quotient)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (tcmp_start)
                    begin
                        state_next = S_TCMP;
                    end
                    else if (fade_cmd_in)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_TCMP:
            begin
                if (tcmp_st.done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_MUL:
            begin
                if (mul_st.done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command execution, evaluated in the apply cycle
    always_comb
    begin
        logic [BRIGHT_W-1:0]      stepped;
        logic                     reversal;
        logic signed [BRIGHT_W+1:0] adj;

        brightness_next     = brightness_reg;
        fade_mode_next      = fade_mode_reg;
        lamp_on_next        = lamp_on_reg;
        half_pulses_next    = half_pulses_reg;
        step_interval_next  = step_interval_reg;
        low_bound_next      = low_bound_reg;
        high_bound_next     = high_bound_reg;
        last_step_time_next = last_step_time_reg;
        wrote_next          = wrote_reg;
        stepped  = '0;
        reversal = 1'b0;
        adj = $signed({2'b00, brightness_reg})
            + $signed({{2{amount_reg[AMOUNT_W-1]}}, amount_reg});

        if (state_reg == S_APPLY)
        begin
            wrote_next = 1'b0;
            case (op_reg)
                OP_TICK:
                begin
                    if (tick_active_reg && tcmp_elapsed)
                    begin
                        if (fade_mode_reg == MODE_UP)
                        begin
                            stepped = brightness_reg + 1'b1;
                            brightness_next = stepped;
                            if (stepped >= BRIGHT_W'(high_bound_reg))
                            begin
                                fade_mode_next = MODE_DOWN;
                                reversal = 1'b1;
                            end
                        end
                        else if (fade_mode_reg == MODE_DOWN)
                        begin
                            stepped = brightness_reg - 1'b1;
                            brightness_next = stepped;
                            if (stepped <= BRIGHT_W'(low_bound_reg))
                            begin
                                fade_mode_next = MODE_UP;
                                reversal = 1'b1;
                            end
                        end
                        // each reversal spends one half-pulse while any remain
                        if (reversal && (half_pulses_reg != '0))
                        begin
                            half_pulses_next = half_pulses_reg - 1'b1;
                            if (half_pulses_reg == PULSES_W'(1))
                            begin
                                fade_mode_next = MODE_OFF;
                            end
                        end
                        last_step_time_next = now_reg;
                        wrote_next = 1'b1;
                    end
                end
                OP_HARD_ON:
                begin
                    brightness_next = BRIGHT_W'(LEVEL_MAX);
                    lamp_on_next = 1'b1;
                    wrote_next = 1'b1;
                end
                OP_HARD_OFF:
                begin
                    brightness_next = '0;
                    lamp_on_next = 1'b0;
                    wrote_next = 1'b1;
                end
                OP_TOGGLE:
                begin
                    fade_mode_next = MODE_OFF;
                    if (lamp_on_reg)
                    begin
                        brightness_next = '0;
                        lamp_on_next = 1'b0;
                    end
                    else
                    begin
                        brightness_next = BRIGHT_W'(LEVEL_MAX);
                        lamp_on_next = 1'b1;
                    end
                    wrote_next = 1'b1;
                end
                OP_ADJUST:
                begin
                    // clamp to the 0..255 level range
                    if (adj[BRIGHT_W+1])
                    begin
                        brightness_next = '0;
                    end
                    else if (adj > $signed((BRIGHT_W+2)'(LEVEL_MAX)))
                    begin
                        brightness_next = BRIGHT_W'(LEVEL_MAX);
                    end
                    else
                    begin
                        brightness_next = adj[BRIGHT_W-1:0];
                    end
                    wrote_next = 1'b1;
                end
                OP_FADE_ONCE:
                begin
                    if ((dir_reg == MODE_UP) || (dir_reg == MODE_OFF))
                    begin
                        fade_mode_next = MODE_UP;
                        brightness_next = BRIGHT_W'(lo_reg);
                    end
                    else if (dir_reg == MODE_DOWN)
                    begin
                        fade_mode_next = MODE_DOWN;
                        brightness_next = BRIGHT_W'(hi_reg);
                    end
                    low_bound_next = lo_reg;
                    high_bound_next = hi_reg;
                    step_interval_next = new_interval;
                    half_pulses_next = PULSES_W'(1);
                end
                OP_FADE_REP:
                begin
                    low_bound_next = lo_reg;
                    high_bound_next = hi_reg;
                    step_interval_next = new_interval;
                    half_pulses_next = {reps_reg, 1'b0};
                    if (fade_mode_reg == MODE_OFF)
                    begin
                        fade_mode_next = MODE_UP;
                    end
                end
                OP_FADE_EVER:
                begin
                    low_bound_next = lo_reg;
                    high_bound_next = hi_reg;
                    step_interval_next = new_interval;
                    if (fade_mode_reg == MODE_OFF)
                    begin
                        fade_mode_next = MODE_UP;
                    end
                end
                OP_STOP:
                begin
                    fade_mode_next = MODE_OFF;
                    half_pulses_next = '0;
                end
                OP_FADE_TO:
                begin
                    step_interval_next = new_interval;
                    low_bound_next = brightness_reg[LEVEL_W-1:0];
                    high_bound_next = endl_reg;
                    if (brightness_reg > BRIGHT_W'(endl_reg))
                    begin
                        fade_mode_next = MODE_DOWN;
                        low_bound_next = endl_reg;
                    end
                    else if (brightness_reg < BRIGHT_W'(endl_reg))
                    begin
                        fade_mode_next = MODE_UP;
                    end
                    else
                    begin
                        fade_mode_next = MODE_OFF;
                    end
                    half_pulses_next = PULSES_W'(1);
                end
                default:
                begin
                    // unknown op: report state unchanged
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            brightness_reg     <= '0;
            fade_mode_reg      <= MODE_OFF;
            lamp_on_reg        <= 1'b0;
            half_pulses_reg    <= '0;
            step_interval_reg  <= '0;
            low_bound_reg      <= '0;
            high_bound_reg     <= '0;
            last_step_time_reg <= '0;
            wrote_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            brightness_reg     <= brightness_next;
            fade_mode_reg      <= fade_mode_next;
            lamp_on_reg        <= lamp_on_next;
            half_pulses_reg    <= half_pulses_next;
            step_interval_reg  <= step_interval_next;
            low_bound_reg      <= low_bound_next;
            high_bound_reg     <= high_bound_next;
            last_step_time_reg <= last_step_time_next;
            wrote_reg          <= wrote_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command word and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= item.op;
            now_reg         <= item.now_us;
            lo_reg          <= item.low_level;
            hi_reg          <= item.high_level;
            dir_reg         <= item.direction;
            reps_reg        <= item.repeats;
            amount_reg      <= item.amount;
            endl_reg        <= item.end_level;
            tick_active_reg <= tick_active_in;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_duty_reg    <= brightness_reg[DUTY_BITS-1:0];
            out_written_reg <= wrote_reg;
            out_mode_reg    <= fade_mode_reg;
            out_lamp_reg    <= lamp_on_reg;
            out_pulses_reg  <= half_pulses_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pwm_duty    = out_duty_reg;
    assign result.pwm_written = out_written_reg;
    assign result.fade_mode   = out_mode_reg;
    assign result.lamp_on     = out_lamp_reg;
    assign result.pulses_left = out_pulses_reg;

    // a new word never lands on a serial unit still at work
    a_units_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!tcmp_st.busy && !mul_st.busy && !div_st.busy))
        else $error("word accepted while a serial unit is busy");

    // the divider picks up the product right after the multiplier finishes
    a_mul_feeds_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) && mul_st.done) |=> div_st.busy)
        else $error("divider did not start after multiply");

    // stop always leaves the engine off with no half-pulses left
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_APPLY) && (op_reg == OP_STOP))
        |=> ((fade_mode_reg == MODE_OFF) && (half_pulses_reg == '0)))
        else $error("stop did not clear fade state");

endmodule

// ----- rtl/lfc_mul1000.sv -----
module lfc_mul1000 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lfc_pkg::DURATION_W-1:0]   duration_ms,
    output lfc_pkg::ser_status_t             status,
    output logic [lfc_pkg::TIME_W-1:0]       product
);
    import lfc_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [SER_CNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]      ms_sh_reg;
    logic [MUL_TAPS-2:0]    hist_reg;
    logic [MUL_CARRY_W-1:0] carry_reg;
    logic [TIME_W-1:0]      prod_reg;

    logic [MUL_TAPS-1:0]    window;
    logic [MUL_SUM_W-1:0]   sum;

    // window[k] is multiplicand bit (i - k) in cycle i
    assign window = {hist_reg, ms_sh_reg[0]};

    always_comb
    begin
        sum = MUL_SUM_W'(carry_reg);
        for (int k = 0; k < MUL_TAPS; k++)
        begin
            sum = sum + MUL_SUM_W'(MS_SCALE[k] & window[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SER_CNT_W'(TIME_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ms_sh_reg <= TIME_W'(duration_ms);
            hist_reg  <= '0;
            carry_reg <= '0;
        end
        else if (busy_reg)
        begin
            ms_sh_reg <= {1'b0, ms_sh_reg[TIME_W-1:1]};
            hist_reg  <= window[MUL_TAPS-2:0];
            carry_reg <= sum[MUL_SUM_W-1:1];
            prod_reg  <= {sum[0], prod_reg[TIME_W-1:1]};
        end
    end

    assign status  = '{busy: busy_reg, done: done_reg};
    assign product = prod_reg;

endmodule

// ----- rtl/lfc_div.sv -----
module lfc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfc_pkg::TIME_W-1:0]    dividend,
    input  logic [lfc_pkg::LEVEL_W-1:0]   divisor,
    output lfc_pkg::ser_status_t          status,
    output logic [lfc_pkg::TIME_W-1:0]    quotient
);
    import lfc_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [SER_CNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]      dq_reg;
    logic [LEVEL_W-1:0]     rem_reg;
    logic [LEVEL_W-1:0]     dvs_reg;

    logic [LEVEL_W:0]       trial;
    logic [LEVEL_W:0]       diff;
    logic                   qbit;

    // restoring step; a zero divisor always subtracts, giving all ones
    assign trial = {rem_reg, dq_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SER_CNT_W'(TIME_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[TIME_W-2:0], qbit};
            rem_reg <= qbit ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
        end
    end

    assign status   = '{busy: busy_reg, done: done_reg};
    assign quotient = dq_reg;

endmodule

// ----- rtl/lfc_tcmp.sv -----
module lfc_tcmp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfc_pkg::TIME_W-1:0]    now_us,
    input  logic [lfc_pkg::TIME_W-1:0]    last_time,
    input  logic [lfc_pkg::TIME_W-1:0]    interval,
    output lfc_pkg::ser_status_t          status,
    output logic                          elapsed
);
    import lfc_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [SER_CNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]      now_sh_reg;
    logic [TIME_W-1:0]      last_sh_reg;
    logic [TIME_W-1:0]      int_sh_reg;
    logic                   dborrow_reg;
    logic                   cborrow_reg;

    logic n_bit;
    logic l_bit;
    logic i_bit;
    logic d_bit;

    // lsb first: d = now - last, then d - interval; no final borrow means elapsed
    assign n_bit = now_sh_reg[0];
    assign l_bit = last_sh_reg[0];
    assign i_bit = int_sh_reg[0];
    assign d_bit = n_bit ^ l_bit ^ dborrow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SER_CNT_W'(TIME_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            now_sh_reg  <= now_us;
            last_sh_reg <= last_time;
            int_sh_reg  <= interval;
            dborrow_reg <= 1'b0;
            cborrow_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            now_sh_reg  <= {1'b0, now_sh_reg[TIME_W-1:1]};
            last_sh_reg <= {1'b0, last_sh_reg[TIME_W-1:1]};
            int_sh_reg  <= {1'b0, int_sh_reg[TIME_W-1:1]};
            dborrow_reg <= (!n_bit && l_bit) || (!(n_bit ^ l_bit) && dborrow_reg);
            cborrow_reg <= (!d_bit && i_bit) || (!(d_bit ^ i_bit) && cborrow_reg);
        end
    end

    assign status  = '{busy: busy_reg, done: done_reg};
    assign elapsed = !cborrow_reg;

endmodule
